[sv/plcs_pkg.sv]
// Shared types and constants for the piecewise-linear contrast stretch core.
// Depends on nothing; every other file refers to it by scoped names.
package plcs_pkg;

    // Pixel field width and lookup-table depth (one entry per input level)
    localparam int PIX_W     = 8;
    localparam int TBL_DEPTH = 1 << PIX_W;

    // Grey scale of the transfer curve; its top point is (TOP, TOP)
    localparam int GREY_LEVELS = 256;

    // Unsigned level width: holds the top level and any 8-bit knee
    localparam int LVL_W = ($clog2(GREY_LEVELS) > PIX_W) ? $clog2(GREY_LEVELS) + 1 : PIX_W + 1;
    // Signed width of a segment extent dx or dy
    localparam int SW    = LVL_W + 1;
    // Width of |dy| * t, t being an offset along the pixel axis
    localparam int NUM_W = LVL_W + PIX_W;
    // Divider step counter
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(GREY_LEVELS - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_LOW_KNEE   = 3'd0,
        REG_IN_HIGH_KNEE  = 3'd1,
        REG_OUT_LOW_KNEE  = 3'd2,
        REG_OUT_HIGH_KNEE = 3'd3
    } cfg_reg_t;

    // Current knee settings
    typedef struct packed {
        logic [PIX_W-1:0] in_low_knee;
        logic [PIX_W-1:0] in_high_knee;
        logic [PIX_W-1:0] out_low_knee;
        logic [PIX_W-1:0] out_high_knee;
    } knee_cfg_t;

    // One write into the transfer table
    typedef struct packed {
        logic             en;
        logic [PIX_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } tbl_wr_t;

endpackage

[sv/plcs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plcs_pkg for the operand widths.
module plcs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [plcs_pkg::NUM_W-1:0]  dividend,
    input  logic [plcs_pkg::LVL_W-1:0]  divisor,
    output logic                        done,
    output logic [plcs_pkg::NUM_W-1:0]  quotient,
    output logic [plcs_pkg::LVL_W-1:0]  remainder
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [plcs_pkg::CNT_W-1:0]  cnt_reg;
    logic [plcs_pkg::CNT_W-1:0]  cnt_next;
    logic [plcs_pkg::NUM_W-1:0]  quo_reg;
    logic [plcs_pkg::NUM_W-1:0]  quo_next;
    logic [plcs_pkg::LVL_W-1:0]  rem_reg;
    logic [plcs_pkg::LVL_W-1:0]  rem_next;
    logic [plcs_pkg::LVL_W-1:0]  dvs_reg;
    logic [plcs_pkg::LVL_W:0]    rem_sh;
    logic [plcs_pkg::LVL_W:0]    rem_sub;
    logic                        fits;
    logic                        last_step;

    // One trial subtraction per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[plcs_pkg::NUM_W-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        last_step = cnt_reg == plcs_pkg::CNT_W'(plcs_pkg::NUM_W - 1);
    end

    // Control and next-value selection
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[plcs_pkg::NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[plcs_pkg::LVL_W-1:0] : rem_sh[plcs_pkg::LVL_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // A finished division is never still counting
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while busy");

endmodule

[sv/plcs_builder.sv]
// Sequencer that fills the transfer table, one level at a time, from the knees.
// Depends on plcs_pkg and instantiates plcs_div for the segment quotient.
module plcs_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  plcs_pkg::knee_cfg_t  knees,
    output logic                 busy,
    output plcs_pkg::tbl_wr_t    tbl_wr
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEL,
        B_MUL,
        B_START,
        B_WAIT,
        B_WR
    } bstate_t;

    bstate_t                          state_reg;
    bstate_t                          state_next;
    logic [plcs_pkg::PIX_W-1:0]       addr_reg;
    logic [plcs_pkg::PIX_W-1:0]       addr_next;

    // Segment selection for the current level
    logic [plcs_pkg::PIX_W-1:0]       xs;
    logic [plcs_pkg::PIX_W-1:0]       ys;
    logic [plcs_pkg::LVL_W-1:0]       xe;
    logic [plcs_pkg::LVL_W-1:0]       ye;
    logic signed [plcs_pkg::SW-1:0]   dx_s;
    logic signed [plcs_pkg::SW-1:0]   dy_s;
    logic signed [plcs_pkg::SW-1:0]   ndx;
    logic signed [plcs_pkg::SW-1:0]   ndy;

    // Datapath registers
    logic [plcs_pkg::LVL_W-1:0]       adx_reg;
    logic [plcs_pkg::LVL_W-1:0]       ady_reg;
    logic [plcs_pkg::PIX_W-1:0]       t_reg;
    logic [plcs_pkg::PIX_W-1:0]       ys_reg;
    logic [plcs_pkg::LVL_W-1:0]       ye_reg;
    logic                             neg_reg;
    logic                             zero_reg;
    logic [plcs_pkg::NUM_W-1:0]       prod_reg;
    logic [plcs_pkg::NUM_W-1:0]       prod_next;

    // Divider link
    logic                             div_start;
    logic                             div_done;
    logic [plcs_pkg::NUM_W-1:0]       div_quo;
    logic [plcs_pkg::LVL_W-1:0]       div_rem;

    // Result assembly
    logic signed [plcs_pkg::NUM_W:0]   q_ext;
    logic signed [plcs_pkg::NUM_W:0]   q_floor;
    logic signed [plcs_pkg::NUM_W+1:0] level;
    logic [plcs_pkg::PIX_W-1:0]        level_sat;
    logic [plcs_pkg::PIX_W-1:0]        end_sat;
    logic [plcs_pkg::PIX_W-1:0]        entry;

    // Pick the segment for level addr_reg and its extents
    always_comb
    begin
        if (addr_reg <= knees.in_low_knee)
        begin
            xs = '0;
            ys = '0;
            xe = plcs_pkg::LVL_W'(knees.in_low_knee);
            ye = plcs_pkg::LVL_W'(knees.out_low_knee);
        end
        else if (addr_reg <= knees.in_high_knee)
        begin
            xs = knees.in_low_knee;
            ys = knees.out_low_knee;
            xe = plcs_pkg::LVL_W'(knees.in_high_knee);
            ye = plcs_pkg::LVL_W'(knees.out_high_knee);
        end
        else
        begin
            xs = knees.in_high_knee;
            ys = knees.out_high_knee;
            xe = plcs_pkg::TOP_LEVEL;
            ye = plcs_pkg::TOP_LEVEL;
        end
        dx_s = $signed({1'b0, xe}) - $signed({(plcs_pkg::SW - plcs_pkg::PIX_W)'(0), xs});
        dy_s = $signed({1'b0, ye}) - $signed({(plcs_pkg::SW - plcs_pkg::PIX_W)'(0), ys});
        ndx  = -dx_s;
        ndy  = -dy_s;
    end

    // Magnitude product, registered before the divider
    always_comb
    begin
        prod_next = ady_reg * t_reg;
    end

    // Floor of the signed quotient, offset by the start level, clipped to a pixel
    always_comb
    begin
        q_ext   = $signed({1'b0, div_quo});
        q_floor = neg_reg ? (-q_ext - $signed({{plcs_pkg::NUM_W{1'b0}}, div_rem != '0}))
                          : q_ext;
        level   = $signed({(plcs_pkg::NUM_W + 2 - plcs_pkg::PIX_W)'(0), ys_reg})
                  + $signed({q_floor[plcs_pkg::NUM_W], q_floor});
        if (level < 0)
        begin
            level_sat = '0;
        end
        else if (level > $signed((plcs_pkg::NUM_W + 2)'(255)))
        begin
            level_sat = '1;
        end
        else
        begin
            level_sat = level[plcs_pkg::PIX_W-1:0];
        end
        end_sat = (ye_reg > plcs_pkg::LVL_W'(255)) ? '1 : ye_reg[plcs_pkg::PIX_W-1:0];
        entry   = zero_reg ? end_sat : level_sat;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            B_IDLE:  state_next = B_IDLE;
            B_SEL:   state_next = B_MUL;
            B_MUL:   state_next = B_START;
            B_START: state_next = B_WAIT;
            B_WAIT:
            begin
                if (div_done)
                begin
                    state_next = B_WR;
                end
            end
            B_WR:
            begin
                if (addr_reg == '1)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    state_next = B_SEL;
                    addr_next  = addr_reg + 1'b1;
                end
            end
            default: state_next = B_IDLE;
        endcase
        if (restart)
        begin
            state_next = B_SEL;
            addr_next  = '0;
        end
    end

    // A fresh table is built after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_SEL;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // Per-level operands
    always_ff @(posedge clk)
    begin
        if (state_reg == B_SEL)
        begin
            adx_reg  <= dx_s[plcs_pkg::SW-1] ? ndx[plcs_pkg::LVL_W-1:0]
                                             : dx_s[plcs_pkg::LVL_W-1:0];
            ady_reg  <= dy_s[plcs_pkg::SW-1] ? ndy[plcs_pkg::LVL_W-1:0]
                                             : dy_s[plcs_pkg::LVL_W-1:0];
            t_reg    <= addr_reg - xs;
            ys_reg   <= ys;
            ye_reg   <= ye;
            neg_reg  <= dx_s[plcs_pkg::SW-1] ^ dy_s[plcs_pkg::SW-1];
            zero_reg <= dx_s == '0;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    assign div_start = state_reg == B_START;

    plcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prod_reg),
        .divisor   (adx_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign busy        = state_reg != B_IDLE;
    assign tbl_wr.en   = state_reg == B_WR;
    assign tbl_wr.addr = addr_reg;
    assign tbl_wr.data = entry;

    // A table entry is written only once its division has finished
    a_wr_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WR |-> $past(state_reg) == B_WAIT)
        else $error("table write without a finished division");

    // A knee change always starts the sweep over from level zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> state_reg == B_SEL && addr_reg == '0)
        else $error("table rebuild did not restart");

endmodule

[sv/plcs_lut.sv]
// Transfer table memory with the pixel read path and output register.
// Depends on plcs_pkg; the table is written by plcs_builder.
module plcs_lut (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plcs_pkg::tbl_wr_t           tbl_wr,
    input  logic                        building,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [plcs_pkg::PIX_W-1:0]  pixel_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [plcs_pkg::PIX_W-1:0]  pixel_out
);

    logic [plcs_pkg::PIX_W-1:0]  mem [plcs_pkg::TBL_DEPTH];
    logic [plcs_pkg::PIX_W-1:0]  rd_data_reg;
    logic [plcs_pkg::PIX_W-1:0]  out_data_reg;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        s1_move;
    logic                        in_fire;

    // Handshake: read stage advances whenever the output register frees up
    always_comb
    begin
        s1_move  = !out_valid_reg || out_ready;
        in_ready = !building && (!s1_valid_reg || s1_move);
        in_fire  = in_valid && in_ready;

        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = s1_move ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table write port and registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            mem[tbl_wr.addr] <= tbl_wr.data;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[pixel_in];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_data_reg <= rd_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = out_data_reg;

    // A read result waiting behind a stalled output keeps its data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(rd_data_reg))
        else $error("stalled table read lost its data");

    // An item reaches the output only through the read stage
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output item without a table read");

endmodule

[sv/piecewise_linear_contrast_stretch_core.sv]
// Piecewise-linear contrast stretch: each 8-bit grey pixel is mapped through a
// 256-entry transfer table that holds the three-segment curve through (0,0),
// (x1,y1), (x2,y2) and the top level. Pixels stream at one item per clock unless
// out_ready or a rebuild holds them, through the read and output registers; the
// table's single read port sets that rate. After reset and after every
// configuration write a sequencer rebuilds the table, taking each entry through
// select, multiply, divider start, wait and write (one bit per cycle in its
// divider); in_ready stays low meanwhile. cfg_ready is always high; a write to an
// index past the four knee registers is ignored but still restarts the build.
module piecewise_linear_contrast_stretch_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plcs_pkg::PIX_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [plcs_pkg::PIX_W-1:0]      pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [plcs_pkg::PIX_W-1:0]      pixel_out
);

    plcs_pkg::knee_cfg_t  knees_reg;
    plcs_pkg::knee_cfg_t  knees_next;
    plcs_pkg::tbl_wr_t    tbl_wr;
    logic                 cfg_fire;
    logic                 building;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Knee register decode
    always_comb
    begin
        knees_next = knees_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                plcs_pkg::REG_IN_LOW_KNEE:   knees_next.in_low_knee   = cfg_data;
                plcs_pkg::REG_IN_HIGH_KNEE:  knees_next.in_high_knee  = cfg_data;
                plcs_pkg::REG_OUT_LOW_KNEE:  knees_next.out_low_knee  = cfg_data;
                plcs_pkg::REG_OUT_HIGH_KNEE: knees_next.out_high_knee = cfg_data;
                default:                     knees_next = knees_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knees_reg.in_low_knee   <= 8'd50;
            knees_reg.in_high_knee  <= 8'd110;
            knees_reg.out_low_knee  <= 8'd10;
            knees_reg.out_high_knee <= 8'd110;
        end
        else
        begin
            knees_reg <= knees_next;
        end
    end

    plcs_builder u_builder (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_fire),
        .knees   (knees_reg),
        .busy    (building),
        .tbl_wr  (tbl_wr)
    );

    plcs_lut u_lut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tbl_wr    (tbl_wr),
        .building  (building),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

endmodule

[verif/plcs_checker.sv]
// Checker for the contrast stretch core: tracks the knee registers, predicts
// each stretched pixel and compares it with what the core delivers.
// Depends on plcs_pkg for widths and register indexes.
module plcs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [plcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plcs_pkg::PIX_W-1:0]      cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [plcs_pkg::PIX_W-1:0]      pixel_in,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [plcs_pkg::PIX_W-1:0]      pixel_out,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Checker's own copy of the knees
    logic [plcs_pkg::PIX_W-1:0] x1_q, x2_q, y1_q, y2_q;

    // Stretched pixels still owed by the core, oldest first
    logic [plcs_pkg::PIX_W-1:0] stretched_q[$];

    // Quotient rounded toward minus infinity
    function automatic int floor_quot(input int n, input int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    // One segment: start y plus slope times offset, or end y when flat in x
    function automatic int segment_level(input int p, input int xs, input int ys,
                                         input int xe, input int ye);
        int dx;
        dx = xe - xs;
        if (dx == 0)
            return ye;
        return ys + floor_quot((ye - ys) * (p - xs), dx);
    endfunction

    // Expected output level for one input pixel under the current knees
    function automatic logic [plcs_pkg::PIX_W-1:0] stretch_level(
        input logic [plcs_pkg::PIX_W-1:0] pix);
        int p, x1, x2, y1, y2, top, r;
        p   = int'(pix);
        x1  = int'(x1_q);
        x2  = int'(x2_q);
        y1  = int'(y1_q);
        y2  = int'(y2_q);
        top = plcs_pkg::GREY_LEVELS - 1;
        if (p <= x1)
            r = segment_level(p, 0, 0, x1, y1);
        else if (p <= x2)
            r = segment_level(p, x1, y1, x2, y2);
        else
            r = segment_level(p, x2, y2, top, top);
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return plcs_pkg::PIX_W'(r);
    endfunction

    // Sample all three channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        logic [plcs_pkg::PIX_W-1:0] want;
        if (!rst_n)
        begin
            x1_q    <= 8'd50;
            x2_q    <= 8'd110;
            y1_q    <= 8'd10;
            y2_q    <= 8'd110;
            errors  <= 0;
            pending <= 0;
            stretched_q.delete();
        end
        else
        begin
            // register writes; unknown indexes leave the knees alone
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    plcs_pkg::REG_IN_LOW_KNEE:   x1_q <= cfg_data;
                    plcs_pkg::REG_IN_HIGH_KNEE:  x2_q <= cfg_data;
                    plcs_pkg::REG_OUT_LOW_KNEE:  y1_q <= cfg_data;
                    plcs_pkg::REG_OUT_HIGH_KNEE: y2_q <= cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                stretched_q.push_back(stretch_level(pixel_in));

            if (out_valid && out_ready)
            begin
                if (stretched_q.size() == 0)
                begin
                    $display("%0t: pixel_out mismatch, expected none actual %0d",
                             $time, pixel_out);
                    errors <= errors + 1;
                end
                else
                begin
                    want = stretched_q.pop_front();
                    if (pixel_out !== want)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                                 $time, want, pixel_out);
                        errors <= errors + 1;
                    end
                end
            end

            // items accepted but not yet delivered
            pending <= stretched_q.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the contrast stretch testbench: clock, reset, knee settings, pixel
// stimulus with bursts and output stalls, and the verdict.
// Depends on plcs_pkg, the core and plcs_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_KNEE_REGS = 4;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 8;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [plcs_pkg::PIX_W-1:0]     cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [plcs_pkg::PIX_W-1:0]     pixel_in  = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [plcs_pkg::PIX_W-1:0]     pixel_out;

    int errors;
    int pending;
    int cycles = 0;

    // Sender burst bookkeeping
    int burst_left = 0;

    // Knees currently programmed, used to aim pixels at the breakpoints
    plcs_pkg::knee_cfg_t knees = '{8'd50, 8'd110, 8'd10, 8'd110};

    // Fixed settings covering the extremes and odd shapes of the curve
    plcs_pkg::knee_cfg_t fixed_knees [6] = '{
        '{8'd50,  8'd110, 8'd10,  8'd110},  // default
        '{8'd0,   8'd0,   8'd0,   8'd0},    // flat-in-x first and middle
        '{8'd255, 8'd255, 8'd255, 8'd255},  // everything on the first segment
        '{8'd0,   8'd255, 8'd255, 8'd0},    // falling middle segment
        '{8'd200, 8'd30,  8'd100, 8'd20},   // knees out of order
        '{8'd255, 8'd0,   8'd0,   8'd255}   // out of order at the extremes
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    piecewise_linear_contrast_stretch_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

    plcs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .errors    (errors),
        .pending   (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stalls: switch between stall styles every so often
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_cnt  = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 256);
        end
        else
            mode_left <= mode_left - 1;
        stall_cnt <= stall_cnt + 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_cnt[2];
        endcase
    end

    // Present one pixel and hold it until accepted, then maybe pause
    task automatic send_pixel(input logic [plcs_pkg::PIX_W-1:0] p);
        int gap;
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left = burst_left - 1;
    endtask

    // Hold the write until taken; valid is lowered by the caller
    task automatic write_reg(input logic [plcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plcs_pkg::PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Pick a pixel, often at or next to a breakpoint
    function automatic logic [plcs_pkg::PIX_W-1:0] pick_pixel();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return knees.in_low_knee;
            3:       return knees.in_low_knee + 8'd1;
            4:       return knees.in_low_knee - 8'd1;
            5:       return knees.in_high_knee;
            6:       return knees.in_high_knee + 8'd1;
            7:       return knees.in_high_knee - 8'd1;
            default: return plcs_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Let every owed pixel come out, then give the pipe time to empty;
    // the first edge lets the checker count the last accepted item
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [plcs_pkg::PIX_W-1:0] edge_pixels [12] = '{
        8'd0, 8'd1, 8'd49, 8'd50, 8'd51, 8'd109,
        8'd110, 8'd111, 8'd254, 8'd255, 8'h55, 8'hAA
    };

    initial
    begin
        plcs_pkg::knee_cfg_t k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels under the reset knees
        foreach (edge_pixels[i])
            send_pixel(edge_pixels[i]);
        drain();

        // phases with new knees each time
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 6)
                k = fixed_knees[ph];
            else
            begin
                k.in_low_knee   = plcs_pkg::PIX_W'($urandom_range(0, 255));
                k.in_high_knee  = plcs_pkg::PIX_W'($urandom_range(0, 255));
                k.out_low_knee  = plcs_pkg::PIX_W'($urandom_range(0, 255));
                k.out_high_knee = plcs_pkg::PIX_W'($urandom_range(0, 255));
            end
            write_reg(plcs_pkg::REG_IN_LOW_KNEE,   k.in_low_knee);
            write_reg(plcs_pkg::REG_IN_HIGH_KNEE,  k.in_high_knee);
            write_reg(plcs_pkg::REG_OUT_LOW_KNEE,  k.out_low_knee);
            write_reg(plcs_pkg::REG_OUT_HIGH_KNEE, k.out_high_knee);
            // an index past the knees must change nothing
            write_reg(plcs_pkg::CFG_IDX_W'($urandom_range(NUM_KNEE_REGS,
                                                          (1 << plcs_pkg::CFG_IDX_W) - 1)),
                      plcs_pkg::PIX_W'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;
            knees = k;

            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pick_pixel());
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
sv/plcs_pkg.sv
sv/plcs_div.sv
sv/plcs_builder.sv
sv/plcs_lut.sv
sv/piecewise_linear_contrast_stretch_core.sv
verif/plcs_checker.sv
verif/testbench.sv
